// File: hw/rtl/uuenc_pkg.sv
// shared types, constants and helper functions of the uuencode line encoder
`timescale 1ns / 1ps
`default_nettype none

package uuenc_pkg;

    // line geometry
    localparam int BYTES_PER_LINE = 45;
    localparam int STORE_DEPTH    = ((BYTES_PER_LINE + 2) / 3) * 4;
    localparam int IDX_W          = $clog2(STORE_DEPTH + 1);
    localparam int CNT_W          = $clog2(BYTES_PER_LINE + 1);

    // character constants
    localparam logic [7:0] CHAR_OFFSET = 8'd32;
    localparam logic [7:0] CHAR_NL     = 8'd10;
    localparam logic [7:0] REPL_RESET  = 8'd96;

    // position of a byte within its three-byte group
    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2
    } t_phase;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_ADD2,
        ST_LEN,
        ST_RD,
        ST_DATA,
        ST_PEND,
        ST_PAD,
        ST_NL,
        ST_TERM,
        ST_TNL
    } t_state;

    // which character goes into the output register
    typedef enum logic [2:0] {
        EMIT_LEN,
        EMIT_DATA,
        EMIT_PEND,
        EMIT_PAD,
        EMIT_NL,
        EMIT_TERM
    } t_emit_sel;

    // controller to datapath
    typedef struct packed {
        logic      capture;
        logic      add;
        logic      add_low;
        logic      rd_en;
        logic      load;
        t_emit_sel sel;
        logic      last;
        logic      clear_line;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic op;
        logic line_full;
        logic widx_zero;
        logic phase_zero;
        logic phase_two;
        logic rd_last;
        logic pad_last;
        logic out_free;
    } t_dp_sts;

    // 6-bit value to printable character, space swapped for the replacement
    function automatic logic [7:0] enc6(input logic [5:0] v, input logic [7:0] repl);
        logic [7:0] c;
        c = {2'b00, v} + CHAR_OFFSET;
        return (v == 6'd0) ? repl : c;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/uuenc_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module uuenc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/uuenc_ctrl.sv
// controller state machine of the uuencode line encoder
`timescale 1ns / 1ps
`default_nettype none

module uuenc_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_op,
    input  wire uuenc_pkg::t_dp_sts i_sts,
    output logic                    o_in_stall,
    output uuenc_pkg::t_dp_cmd      o_cmd
);

    uuenc_pkg::t_state r_state;
    uuenc_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= uuenc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            uuenc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_op || i_sts.line_full) begin
                        n_state = uuenc_pkg::ST_LEN;
                    end else begin
                        n_state = uuenc_pkg::ST_ADD;
                    end
                end
            end
            uuenc_pkg::ST_ADD: begin
                n_state = i_sts.phase_two ? uuenc_pkg::ST_ADD2 : uuenc_pkg::ST_IDLE;
            end
            uuenc_pkg::ST_ADD2: begin
                n_state = uuenc_pkg::ST_IDLE;
            end
            uuenc_pkg::ST_LEN: begin
                if (i_sts.out_free) begin
                    if (!i_sts.widx_zero) begin
                        n_state = uuenc_pkg::ST_RD;
                    end else if (!i_sts.phase_zero) begin
                        n_state = uuenc_pkg::ST_PEND;
                    end else begin
                        n_state = uuenc_pkg::ST_NL;
                    end
                end
            end
            uuenc_pkg::ST_RD: begin
                n_state = uuenc_pkg::ST_DATA;
            end
            uuenc_pkg::ST_DATA: begin
                if (i_sts.out_free) begin
                    if (!i_sts.rd_last) begin
                        n_state = uuenc_pkg::ST_RD;
                    end else if (!i_sts.phase_zero) begin
                        n_state = uuenc_pkg::ST_PEND;
                    end else begin
                        n_state = uuenc_pkg::ST_NL;
                    end
                end
            end
            uuenc_pkg::ST_PEND: begin
                if (i_sts.out_free) begin
                    n_state = uuenc_pkg::ST_PAD;
                end
            end
            uuenc_pkg::ST_PAD: begin
                if (i_sts.out_free && i_sts.pad_last) begin
                    n_state = uuenc_pkg::ST_NL;
                end
            end
            uuenc_pkg::ST_NL: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.op ? uuenc_pkg::ST_TERM : uuenc_pkg::ST_ADD;
                end
            end
            uuenc_pkg::ST_TERM: begin
                if (i_sts.out_free) begin
                    n_state = uuenc_pkg::ST_TNL;
                end
            end
            uuenc_pkg::ST_TNL: begin
                if (i_sts.out_free) begin
                    n_state = uuenc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = uuenc_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd            = '0;
        o_cmd.sel        = uuenc_pkg::EMIT_NL;
        o_in_stall       = 1'b1;
        case (r_state)
            uuenc_pkg::ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            uuenc_pkg::ST_ADD: begin
                o_cmd.add = 1'b1;
            end
            uuenc_pkg::ST_ADD2: begin
                o_cmd.add_low = 1'b1;
            end
            uuenc_pkg::ST_LEN: begin
                o_cmd.load = i_sts.out_free;
                o_cmd.sel  = uuenc_pkg::EMIT_LEN;
            end
            uuenc_pkg::ST_RD: begin
                o_cmd.rd_en = 1'b1;
            end
            uuenc_pkg::ST_DATA: begin
                o_cmd.load = i_sts.out_free;
                o_cmd.sel  = uuenc_pkg::EMIT_DATA;
            end
            uuenc_pkg::ST_PEND: begin
                o_cmd.load = i_sts.out_free;
                o_cmd.sel  = uuenc_pkg::EMIT_PEND;
            end
            uuenc_pkg::ST_PAD: begin
                o_cmd.load = i_sts.out_free;
                o_cmd.sel  = uuenc_pkg::EMIT_PAD;
            end
            uuenc_pkg::ST_NL: begin
                o_cmd.load       = i_sts.out_free;
                o_cmd.sel        = uuenc_pkg::EMIT_NL;
                o_cmd.last       = !i_sts.op;
                o_cmd.clear_line = i_sts.out_free;
            end
            uuenc_pkg::ST_TERM: begin
                o_cmd.load = i_sts.out_free;
                o_cmd.sel  = uuenc_pkg::EMIT_TERM;
            end
            uuenc_pkg::ST_TNL: begin
                o_cmd.load = i_sts.out_free;
                o_cmd.sel  = uuenc_pkg::EMIT_NL;
                o_cmd.last = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/uuenc_dp.sv
// datapath of the uuencode line encoder: packing, line store, output register
`timescale 1ns / 1ps
`default_nettype none

module uuenc_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire uuenc_pkg::t_dp_cmd i_cmd,
    output uuenc_pkg::t_dp_sts      o_sts,
    input  wire logic               i_op,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic               i_cfg_we,
    input  wire logic [7:0]         i_cfg_data,
    input  wire logic               i_out_stall,
    output logic                    o_out_valid,
    output logic      [7:0]         o_out_char,
    output logic                    o_last_of_run
);

    localparam int ADDR_W = $clog2(uuenc_pkg::STORE_DEPTH);

    logic                              r_op;
    logic [7:0]                        r_byte;
    logic [7:0]                        r_repl;
    logic [5:0]                        r_pending;
    logic [uuenc_pkg::CNT_W-1:0]       r_count;
    uuenc_pkg::t_phase                 r_phase;
    logic [uuenc_pkg::IDX_W-1:0]       r_widx;
    logic [uuenc_pkg::IDX_W-1:0]       r_ridx;
    logic [1:0]                        r_pad;
    logic                              r_out_valid;
    logic [7:0]                        r_out_char;
    logic                              r_out_last;

    logic [5:0]                        add_val;
    logic [5:0]                        n_pending;
    logic [5:0]                        ram_wdata;
    logic [5:0]                        ram_rdata;
    logic [uuenc_pkg::IDX_W-1:0]       ridx_inc;
    logic [7:0]                        n_char;
    logic                              out_free;

    // pack the incoming byte into the current group
    always_comb begin
        add_val   = r_byte[7:2];
        n_pending = {r_byte[1:0], 4'b0000};
        case (r_phase)
            uuenc_pkg::PH_0: begin
                add_val   = r_byte[7:2];
                n_pending = {r_byte[1:0], 4'b0000};
            end
            uuenc_pkg::PH_1: begin
                add_val   = r_pending | {2'b00, r_byte[7:4]};
                n_pending = {r_byte[3:0], 2'b00};
            end
            uuenc_pkg::PH_2: begin
                add_val   = r_pending | {4'b0000, r_byte[7:6]};
                n_pending = 6'd0;
            end
            default: begin
                add_val   = r_byte[7:2];
                n_pending = {r_byte[1:0], 4'b0000};
            end
        endcase
    end

    assign ram_wdata = i_cmd.add_low ? r_byte[5:0] : add_val;
    assign ridx_inc  = r_ridx + uuenc_pkg::IDX_W'(1);

    // line store
    uuenc_ram #(
        .WIDTH (6),
        .DEPTH (uuenc_pkg::STORE_DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.add | i_cmd.add_low),
        .i_waddr (r_widx[ADDR_W-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_ridx[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // input capture and configuration register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_op;
            r_byte <= i_data_byte;
        end
        if (!i_rst_n) begin
            r_repl <= uuenc_pkg::REPL_RESET;
        end else if (i_cfg_we) begin
            r_repl <= i_cfg_data;
        end
    end

    // line state: count, phase, write index, pending bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_line) begin
            r_count   <= '0;
            r_phase   <= uuenc_pkg::PH_0;
            r_widx    <= '0;
            r_pending <= 6'd0;
        end else if (i_cmd.add) begin
            r_count   <= r_count + uuenc_pkg::CNT_W'(1);
            r_widx    <= r_widx + uuenc_pkg::IDX_W'(1);
            r_pending <= n_pending;
            case (r_phase)
                uuenc_pkg::PH_0: r_phase <= uuenc_pkg::PH_1;
                uuenc_pkg::PH_1: r_phase <= uuenc_pkg::PH_2;
                default:         r_phase <= uuenc_pkg::PH_0;
            endcase
        end else if (i_cmd.add_low) begin
            r_widx <= r_widx + uuenc_pkg::IDX_W'(1);
        end
    end

    // read index and padding counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            case (i_cmd.sel)
                uuenc_pkg::EMIT_LEN:  r_ridx <= '0;
                uuenc_pkg::EMIT_DATA: r_ridx <= ridx_inc;
                uuenc_pkg::EMIT_PEND: r_pad  <= r_phase;
                uuenc_pkg::EMIT_PAD:  r_pad  <= r_pad + 2'd1;
                default: begin
                end
            endcase
        end
    end

    // character selection
    always_comb begin
        case (i_cmd.sel)
            uuenc_pkg::EMIT_LEN:  n_char = {{(8 - uuenc_pkg::CNT_W){1'b0}}, r_count}
                                           + uuenc_pkg::CHAR_OFFSET;
            uuenc_pkg::EMIT_DATA: n_char = uuenc_pkg::enc6(ram_rdata, r_repl);
            uuenc_pkg::EMIT_PEND: n_char = uuenc_pkg::enc6(r_pending, r_repl);
            uuenc_pkg::EMIT_PAD:  n_char = uuenc_pkg::enc6(6'd0, r_repl);
            uuenc_pkg::EMIT_TERM: n_char = r_repl;
            default:              n_char = uuenc_pkg::CHAR_NL;
        endcase
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load) begin
            r_out_char <= n_char;
            r_out_last <= i_cmd.last;
        end
    end

    // status to the controller
    always_comb begin
        o_sts.op         = r_op;
        o_sts.line_full  = (r_count >= uuenc_pkg::CNT_W'(uuenc_pkg::BYTES_PER_LINE));
        o_sts.widx_zero  = (r_widx == '0);
        o_sts.phase_zero = (r_phase == uuenc_pkg::PH_0);
        o_sts.phase_two  = (r_phase == uuenc_pkg::PH_2);
        o_sts.rd_last    = (ridx_inc == r_widx);
        o_sts.pad_last   = (r_pad == 2'd2);
        o_sts.out_free   = out_free;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_char    = r_out_char;
    assign o_last_of_run = r_out_last;

endmodule

`default_nettype wire

// File: hw/rtl/uuencode_line_encoder.sv
// top level of the uuencode line encoder
//
// Input channel (i_in_valid / o_in_stall): one beat carries i_op and i_data_byte.
// i_op 0 adds a data byte to the current line of up to 45 bytes; i_op 1 ends
// the stream and i_data_byte is ignored. A data byte arriving on a full line
// first flushes that line. End of stream flushes the line and adds the
// terminator line (replacement character, newline).
// Output channel (o_out_valid / i_out_stall): one character a beat, with
// o_last_of_run marking the final character caused by one input beat.
// Config channel (i_cfg_valid / o_cfg_ready): writes the space replacement
// character; ready is always high, write only while the block is idle.
// One input beat is taken at a time: a byte that starts no flush is written
// to the line store, with a second value at the end of its group. A flush
// emits the length, padding, newline and terminator characters and each
// stored character, which comes from the line store through its registered
// read port. When the receiver stalls, the output register holds its beat
// and the sequencer waits.
// Reset (synchronous) empties the line and sets the replacement to a backquote.
`timescale 1ns / 1ps
`default_nettype none

module uuencode_line_encoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_op,
    input  wire logic [7:0] i_data_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic      [7:0] o_out_char,
    output logic            o_last_of_run,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);

    uuenc_pkg::t_dp_cmd cmd;
    uuenc_pkg::t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    // sequencer
    uuenc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // datapath
    uuenc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (i_op),
        .i_data_byte   (i_data_byte),
        .i_cfg_we      (i_cfg_valid & o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_char    (o_out_char),
        .o_last_of_run (o_last_of_run)
    );

endmodule

`default_nettype wire

// File: bench/tb_uuencode_line_encoder.sv
// self-checking testbench of the uuencode line encoder
`timescale 1ns / 1ps

module tb_uuencode_line_encoder;

    // input beat codes
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEM_TARGET    = 200;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_beat;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic       i_op          = OP_DATA;
    logic [7:0] i_data_byte   = 8'd0;
    logic       i_out_stall   = 1'b0;
    logic       i_cfg_valid   = 1'b0;
    logic [7:0] i_cfg_data    = 8'd0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_char;
    logic       o_last_of_run;
    logic       o_cfg_ready;

    // encoder state as predicted by the bench
    logic [5:0] line_vals [uuenc_pkg::STORE_DEPTH];
    logic [5:0] pend_bits = 6'd0;
    logic [7:0] line_len  = 8'd0;
    logic [7:0] repl_char = uuenc_pkg::REPL_RESET;

    logic [7:0] run_chars [$];
    t_char_beat expected_chars [$];
    t_char_beat want;

    int unsigned items_sent  = 0;
    int unsigned mismatches  = 0;
    int unsigned idle_cycles = 0;
    logic        calm        = 1'b0;

    uuencode_line_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_data_byte   (i_data_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_char    (o_out_char),
        .o_last_of_run (o_last_of_run),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // 6-bit value to character, zero goes out as the replacement
    function automatic logic [7:0] to_char(input logic [5:0] v);
        return (v == 6'd0) ? repl_char : ({2'b00, v} + uuenc_pkg::CHAR_OFFSET);
    endfunction

    // length char, stored chars, padded partial group, newline
    task automatic flush_line();
        int unsigned rem;
        int unsigned full;
        rem  = line_len % 3;
        full = (line_len / 3) * 4 + rem;
        run_chars.push_back(line_len + uuenc_pkg::CHAR_OFFSET);
        for (int i = 0; i < full; i++) run_chars.push_back(to_char(line_vals[i]));
        if (rem != 0) begin
            run_chars.push_back(to_char(pend_bits));
            for (int i = rem + 1; i < 4; i++) run_chars.push_back(to_char(6'd0));
        end
        run_chars.push_back(uuenc_pkg::CHAR_NL);
        line_len  = 8'd0;
        pend_bits = 6'd0;
    endtask

    // split one byte into the 6-bit values of its group
    task automatic add_byte(input logic [7:0] b);
        int unsigned idx;
        idx = (line_len / 3) * 4 + line_len % 3;
        case (uuenc_pkg::t_phase'(line_len % 3))
            uuenc_pkg::PH_0: begin
                line_vals[idx] = b[7:2];
                pend_bits      = {b[1:0], 4'b0000};
            end
            uuenc_pkg::PH_1: begin
                line_vals[idx] = pend_bits | {2'b00, b[7:4]};
                pend_bits      = {b[3:0], 2'b00};
            end
            default: begin
                line_vals[idx]     = pend_bits | {4'b0000, b[7:6]};
                line_vals[idx + 1] = b[5:0];
                pend_bits          = 6'd0;
            end
        endcase
        line_len = line_len + 8'd1;
    endtask

    // expected characters caused by one input beat
    task automatic encode_item(input logic op, input logic [7:0] b);
        t_char_beat beat;
        run_chars.delete();
        if (op == OP_DATA) begin
            if (line_len >= uuenc_pkg::BYTES_PER_LINE) flush_line();
            add_byte(b);
        end else begin
            flush_line();
            run_chars.push_back(repl_char);
            run_chars.push_back(uuenc_pkg::CHAR_NL);
        end
        foreach (run_chars[i]) begin
            beat.ch   = run_chars[i];
            beat.last = (i == run_chars.size() - 1);
            expected_chars.push_back(beat);
        end
    endtask

    // one input beat, with an occasional gap before it
    task automatic send_item(input logic op, input logic [7:0] b);
        if (!calm && $urandom_range(0, 99) < 13) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while (!calm && $urandom_range(0, 99) < 13);
        end
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        encode_item(op, b);
        items_sent++;
    endtask

    // random data bytes closed by an end beat with a random ignored byte
    task automatic send_stream(input int unsigned len);
        for (int i = 0; i < len; i++) send_item(OP_DATA, 8'($urandom_range(0, 255)));
        send_item(OP_END, 8'($urandom_range(0, 255)));
    endtask

    // hold off until every expected character is out and the block settles
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_replacement(input logic [7:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        repl_char = val;
    endtask

    // reset replacement: empty stream, one, two and three byte streams
    task automatic test_reset_replacement();
        send_item(OP_END, 8'hFF);
        send_item(OP_DATA, 8'h00);
        send_item(OP_END, 8'h00);
        send_item(OP_DATA, 8'hFF);
        send_item(OP_DATA, 8'h00);
        send_item(OP_END, 8'h5A);
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, 8'hFF);
        send_item(OP_DATA, 8'h80);
        send_item(OP_END, 8'h00);
    endtask

    // lowest, highest and space as the replacement
    task automatic test_replacement_extremes();
        set_replacement(8'h00);
        send_item(OP_DATA, 8'hFF);
        send_item(OP_DATA, 8'hFF);
        send_item(OP_DATA, 8'hFF);
        send_item(OP_DATA, 8'h00);
        send_item(OP_END, 8'hFF);
        set_replacement(8'hFF);
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, 8'h00);
        send_item(OP_END, 8'h00);
        set_replacement(uuenc_pkg::CHAR_OFFSET);
        send_item(OP_DATA, 8'h00);
        send_item(OP_END, 8'hA5);
    endtask

    // full line flushed by the next byte, and a line ending exactly full
    task automatic test_full_line();
        set_replacement(8'($urandom_range(0, 255)));
        send_stream(uuenc_pkg::BYTES_PER_LINE + 1);
        send_stream(uuenc_pkg::BYTES_PER_LINE);
    endtask

    // long stream with no gaps and no stalls
    task automatic test_burst();
        drain();
        calm = 1'b1;
        send_stream(60);
        drain();
        calm = 1'b0;
    endtask

    // mostly short streams, some over several lines, replacement changes between
    task automatic test_random_streams();
        int unsigned len;
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 3) == 0) set_replacement(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 7) == 0) len = $urandom_range(40, 95);
            else len = $urandom_range(0, 12);
            send_stream(len);
        end
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 13);
    end

    // compare each output beat with the oldest expected character
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_chars.size() == 0) begin
                $error("out_char: expected nothing, got %0h", o_out_char);
                mismatches++;
            end else begin
                want = expected_chars.pop_front();
                if (o_out_char !== want.ch) begin
                    $error("out_char: expected %0h, got %0h", want.ch, o_out_char);
                    mismatches++;
                end
                if (o_last_of_run !== want.last) begin
                    $error("last_of_run: expected %0b, got %0b", want.last, o_last_of_run);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_replacement();
        test_replacement_extremes();
        test_full_line();
        test_burst();
        test_random_streams();
        drain();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/uuenc_pkg.sv
hw/rtl/uuenc_ram.sv
hw/rtl/uuenc_ctrl.sv
hw/rtl/uuenc_dp.sv
hw/rtl/uuencode_line_encoder.sv
bench/tb_uuencode_line_encoder.sv
